// ----- rtl/tksm_pkg.sv -----
// ----------------------------------------------------------------------------
// Terminal key sequence matcher package
// Shared types, constants and codes for the key sequence matcher.
// ----------------------------------------------------------------------------
package tksm_pkg;

    localparam int TABLE_ENTRIES_DEF = 128;
    localparam int MAX_SEQ_LEN_DEF   = 8;
    localparam int QUEUE_DEPTH       = 2;
    localparam int TIMEOUT_RESET     = 2;

    typedef enum logic [1:0] {
        CMD_WR_BYTE = 2'd0,
        CMD_WR_CODE = 2'd1,
        CMD_RECV    = 2'd2,
        CMD_TICK    = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_PLAIN   = 2'd0,
        ST_MATCHED = 2'd1,
        ST_UNKNOWN = 2'd2,
        ST_TIMEOUT = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CFG_ACTIVE  = 2'd0,
        CFG_TIMEOUT = 2'd1,
        CFG_STRICT  = 2'd2
    } t_cfg_reg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_RD1,
        S_CUR,
        S_PA,
        S_PB,
        S_NEXT,
        S_CODE
    } t_state;

    typedef struct packed {
        t_cmd        command;
        logic [6:0]  entry_index;
        logic [2:0]  byte_position;
        logic [7:0]  data_byte;
        logic [15:0] key_code;
    } t_in_item;

    typedef struct packed {
        logic [15:0] key_value;
        t_status     status;
    } t_out_item;

endpackage

// ----- rtl/tksm_fifo.sv -----
// ----------------------------------------------------------------------------
// Small queue
// Register-based first-in first-out queue with full and empty flags.
// ----------------------------------------------------------------------------
module tksm_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = tksm_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp, r_rp;
    logic [AW:0]      r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

// ----- rtl/tksm_engine.sv -----
// ----------------------------------------------------------------------------
// Key sequence engine
// Holds the sequence table and walks it one memory read per cycle.
// ----------------------------------------------------------------------------
module tksm_engine #(
    parameter int TABLE_ENTRIES = tksm_pkg::TABLE_ENTRIES_DEF,
    parameter int MAX_SEQ_LEN   = tksm_pkg::MAX_SEQ_LEN_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    input  logic [1:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_data,
    input  tksm_pkg::t_in_item  i_cmd,
    input  logic                i_cmd_empty,
    output logic                o_cmd_pop,
    input  logic                i_res_full,
    output logic                o_res_push,
    output tksm_pkg::t_out_item o_res
);
    localparam int EW = $clog2(TABLE_ENTRIES);
    localparam int PW = $clog2(MAX_SEQ_LEN);
    localparam int KW = $clog2(TABLE_ENTRIES + 1);
    localparam int SEQ_DEPTH = TABLE_ENTRIES << PW;

    tksm_pkg::t_state r_state, n_state;

    logic [7:0]    r_active;
    logic [15:0]   r_timeout;
    logic          r_strict;

    logic          r_matching, n_matching;
    logic [EW-1:0] r_cur, n_cur;
    logic [PW-1:0] r_m, n_m;
    logic [7:0]    r_first, n_first;
    logic [15:0]   r_ticks, n_ticks;
    logic [7:0]    r_c, n_c;
    logic [KW-1:0] r_k, n_k;
    logic [EW-1:0] r_chk, n_chk;
    logic          r_rdv, n_rdv;
    logic [PW-1:0] r_sp, n_sp;
    logic [EW-1:0] r_kf, n_kf;
    logic [PW-1:0] r_j, n_j;
    logic [7:0]    r_pa, n_pa;

    logic [7:0]    r_seq_mem [SEQ_DEPTH];
    logic [15:0]   r_code_mem [TABLE_ENTRIES];
    logic [7:0]    r_sq_q;
    logic [15:0]   r_cd_q;

    logic [EW-1:0] rd_e, cd_a;
    logic [PW-1:0] rd_p;
    logic          seq_we, code_we;
    logic [EW-1:0] wr_e;
    logic [PW-1:0] wr_p;
    logic          e_ok, p_ok;

    logic          go, hit, k_more, m_end, last_j, pb_fail, cur_eq, time_up;
    logic [KW-1:0] n_use;
    logic [PW:0]   m_nx;
    logic [15:0]   tick_nx;
    logic [PW-1:0] j0;

    assign go      = (r_state == tksm_pkg::S_IDLE) && !i_cmd_empty && !i_res_full;
    assign hit     = r_rdv && (r_sq_q == r_c);
    assign n_use   = (32'(r_active) > TABLE_ENTRIES) ? KW'(TABLE_ENTRIES) : KW'(r_active);
    assign k_more  = (r_k < n_use);
    assign m_nx    = {1'b0, r_m} + 1'b1;
    assign m_end   = (32'(m_nx) >= MAX_SEQ_LEN);
    assign last_j  = (r_j == r_m - 1'b1);
    assign pb_fail = (r_pa != r_sq_q);
    assign cur_eq  = (r_sq_q == r_c);
    assign tick_nx = (r_ticks == 16'hFFFF) ? r_ticks : r_ticks + 1'b1;
    assign time_up = (tick_nx >= r_timeout);
    assign j0      = (r_strict && r_m > PW'(1)) ? '0 : r_m - 1'b1;
    assign e_ok    = (32'(i_cmd.entry_index) < TABLE_ENTRIES);
    assign p_ok    = (32'(i_cmd.byte_position) < MAX_SEQ_LEN);
    assign wr_e    = EW'(i_cmd.entry_index);
    assign wr_p    = PW'(i_cmd.byte_position);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tksm_pkg::S_IDLE: begin
                if (go && i_cmd.command == tksm_pkg::CMD_RECV) begin
                    n_state = r_matching ? tksm_pkg::S_CUR : tksm_pkg::S_SCAN;
                end
            end
            tksm_pkg::S_SCAN: begin
                if (hit) begin
                    n_state = r_matching ? tksm_pkg::S_PA : tksm_pkg::S_RD1;
                end else if (!k_more) begin
                    n_state = tksm_pkg::S_IDLE;
                end
            end
            tksm_pkg::S_RD1: begin
                n_state = (r_sq_q == 8'd0) ? tksm_pkg::S_CODE : tksm_pkg::S_IDLE;
            end
            tksm_pkg::S_CUR: begin
                if (cur_eq) begin
                    n_state = m_end ? tksm_pkg::S_CODE : tksm_pkg::S_NEXT;
                end else begin
                    n_state = tksm_pkg::S_SCAN;
                end
            end
            tksm_pkg::S_PA: n_state = tksm_pkg::S_PB;
            tksm_pkg::S_PB: begin
                if (pb_fail) begin
                    n_state = tksm_pkg::S_IDLE;
                end else if (last_j) begin
                    n_state = m_end ? tksm_pkg::S_CODE : tksm_pkg::S_NEXT;
                end else begin
                    n_state = tksm_pkg::S_PA;
                end
            end
            tksm_pkg::S_NEXT: begin
                n_state = (r_sq_q == 8'd0) ? tksm_pkg::S_CODE : tksm_pkg::S_IDLE;
            end
            tksm_pkg::S_CODE: n_state = tksm_pkg::S_IDLE;
            default: n_state = tksm_pkg::S_IDLE;
        endcase
    end

    // Datapath and outputs.
    always_comb begin
        n_matching = r_matching;
        n_cur      = r_cur;
        n_m        = r_m;
        n_first    = r_first;
        n_ticks    = r_ticks;
        n_c        = r_c;
        n_k        = r_k;
        n_chk      = r_chk;
        n_rdv      = r_rdv;
        n_sp       = r_sp;
        n_kf       = r_kf;
        n_j        = r_j;
        n_pa       = r_pa;
        rd_e       = r_cur;
        rd_p       = r_m;
        cd_a       = r_cur;
        seq_we     = 1'b0;
        code_we    = 1'b0;
        o_cmd_pop  = 1'b0;
        o_res_push = 1'b0;
        o_res      = '0;
        unique case (r_state)
            tksm_pkg::S_IDLE: begin
                if (go) begin
                    o_cmd_pop = 1'b1;
                    n_c       = i_cmd.data_byte;
                    unique case (i_cmd.command)
                        tksm_pkg::CMD_WR_BYTE: seq_we  = e_ok && p_ok;
                        tksm_pkg::CMD_WR_CODE: code_we = e_ok;
                        tksm_pkg::CMD_RECV: begin
                            if (!r_matching) begin
                                n_k   = '0;
                                n_sp  = '0;
                                n_rdv = 1'b0;
                            end
                        end
                        tksm_pkg::CMD_TICK: begin
                            if (r_matching) begin
                                n_ticks = tick_nx;
                                if (time_up) begin
                                    n_matching      = 1'b0;
                                    o_res_push      = 1'b1;
                                    o_res.key_value = 16'(r_first);
                                    o_res.status    = tksm_pkg::ST_TIMEOUT;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            tksm_pkg::S_SCAN: begin
                rd_e = r_k[EW-1:0];
                rd_p = r_sp;
                if (hit) begin
                    n_kf  = r_chk;
                    n_rdv = 1'b0;
                    if (r_matching) begin
                        n_j  = j0;
                        rd_e = r_cur;
                        rd_p = j0;
                    end else begin
                        n_cur = r_chk;
                        rd_e  = r_chk;
                        rd_p  = PW'(1);
                    end
                end else if (k_more) begin
                    n_rdv = 1'b1;
                    n_chk = r_k[EW-1:0];
                    n_k   = r_k + 1'b1;
                end else begin
                    n_rdv      = 1'b0;
                    o_res_push = 1'b1;
                    if (r_matching) begin
                        n_matching   = 1'b0;
                        o_res.status = tksm_pkg::ST_UNKNOWN;
                    end else begin
                        o_res.key_value = 16'(r_c);
                        o_res.status    = tksm_pkg::ST_PLAIN;
                    end
                end
            end
            tksm_pkg::S_RD1: begin
                if (r_sq_q != 8'd0) begin
                    n_matching = 1'b1;
                    n_m        = PW'(1);
                    n_first    = r_c;
                    n_ticks    = '0;
                end
            end
            tksm_pkg::S_CUR: begin
                if (cur_eq) begin
                    rd_p = m_nx[PW-1:0];
                end else begin
                    n_k   = KW'(r_cur) + 1'b1;
                    n_sp  = r_m;
                    n_rdv = 1'b0;
                end
            end
            tksm_pkg::S_PA: begin
                n_pa = r_sq_q;
                rd_e = r_kf;
                rd_p = r_j;
            end
            tksm_pkg::S_PB: begin
                if (pb_fail) begin
                    n_matching   = 1'b0;
                    o_res_push   = 1'b1;
                    o_res.status = tksm_pkg::ST_UNKNOWN;
                end else if (last_j) begin
                    n_cur = r_kf;
                    cd_a  = r_kf;
                    rd_e  = r_kf;
                    rd_p  = m_nx[PW-1:0];
                end else if (r_pa == 8'd0) begin
                    // A shared terminator ends the prefix walk; only the last byte is left.
                    n_j  = r_m - 1'b1;
                    rd_p = r_m - 1'b1;
                end else begin
                    n_j  = r_j + 1'b1;
                    rd_p = r_j + 1'b1;
                end
            end
            tksm_pkg::S_NEXT: begin
                if (r_sq_q != 8'd0) begin
                    n_m = m_nx[PW-1:0];
                end
            end
            tksm_pkg::S_CODE: begin
                n_matching      = 1'b0;
                o_res_push      = 1'b1;
                o_res.key_value = r_cd_q;
                o_res.status    = tksm_pkg::ST_MATCHED;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= tksm_pkg::S_IDLE;
            r_active   <= '0;
            r_timeout  <= 16'(tksm_pkg::TIMEOUT_RESET);
            r_strict   <= 1'b0;
            r_matching <= 1'b0;
            r_cur      <= '0;
            r_m        <= '0;
            r_first    <= '0;
            r_ticks    <= '0;
            r_k        <= '0;
            r_rdv      <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_matching <= n_matching;
            r_cur      <= n_cur;
            r_m        <= n_m;
            r_first    <= n_first;
            r_ticks    <= n_ticks;
            r_k        <= n_k;
            r_rdv      <= n_rdv;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    tksm_pkg::CFG_ACTIVE:  r_active  <= i_cfg_data[7:0];
                    tksm_pkg::CFG_TIMEOUT: r_timeout <= i_cfg_data;
                    tksm_pkg::CFG_STRICT:  r_strict  <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_c   <= n_c;
        r_chk <= n_chk;
        r_sp  <= n_sp;
        r_kf  <= n_kf;
        r_j   <= n_j;
        r_pa  <= n_pa;
    end

    always_ff @(posedge i_clk) begin
        if (seq_we) begin
            r_seq_mem[{wr_e, wr_p}] <= i_cmd.data_byte;
        end
        r_sq_q <= r_seq_mem[{rd_e, rd_p}];
    end

    always_ff @(posedge i_clk) begin
        if (code_we) begin
            r_code_mem[wr_e] <= i_cmd.key_code;
        end
        r_cd_q <= r_code_mem[cd_a];
    end

endmodule

// ----- rtl/terminal_key_sequence_matcher_unit.sv -----
// A transfer in is taken while full is low; results leave in order through a
// two-entry result queue. Table writes and ticks are handled in the idle state. A
// received byte that starts no sequence needs a scan of the active entries, one
// entry per cycle through the single read port of the sequence memory; a mismatch
// adds a scan over the remaining entries and a prefix comparison of one byte, or
// of up to MAX_SEQ_LEN - 1 bytes with strict prefix checking, each byte read in
// the PA and PB states.
// ----------------------------------------------------------------------------
// Terminal key sequence matcher
// Command queue in front of a table walking engine, results through a queue.
// ----------------------------------------------------------------------------
module terminal_key_sequence_matcher_unit #(
    parameter int TABLE_ENTRIES = tksm_pkg::TABLE_ENTRIES_DEF,
    parameter int MAX_SEQ_LEN   = tksm_pkg::MAX_SEQ_LEN_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  tksm_pkg::t_in_item  i_item,
    output logic                empty,
    input  logic                pop,
    output tksm_pkg::t_out_item o_result,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_data
);
    localparam int IW = $bits(tksm_pkg::t_in_item);
    localparam int OW = $bits(tksm_pkg::t_out_item);

    logic [IW-1:0]       cmd_q;
    logic                cmd_empty, cmd_pop;
    logic                res_full, res_push;
    tksm_pkg::t_out_item res_item;
    logic [OW-1:0]       res_q;

    assign o_cfg_ready = 1'b1;
    assign o_result    = tksm_pkg::t_out_item'(res_q);

    tksm_fifo #(.WIDTH(IW), .DEPTH(tksm_pkg::QUEUE_DEPTH)) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (IW'(i_item)),
        .o_full  (full),
        .i_pop   (cmd_pop),
        .o_data  (cmd_q),
        .o_empty (cmd_empty)
    );

    tksm_engine #(.TABLE_ENTRIES(TABLE_ENTRIES), .MAX_SEQ_LEN(MAX_SEQ_LEN)) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (tksm_pkg::t_in_item'(cmd_q)),
        .i_cmd_empty (cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (res_item)
    );

    tksm_fifo #(.WIDTH(OW), .DEPTH(tksm_pkg::QUEUE_DEPTH)) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (OW'(res_item)),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_q),
        .o_empty (empty)
    );

endmodule

// ----- verif/terminal_key_sequence_matcher_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key sequence matcher testbench
// Loads sorted key tables and sends terminal bytes and ticks in bursts. A
// behavioral decoder predicts each key code, and a scoreboard checks every
// result popped from the block while the result side stalls on its own.
// ----------------------------------------------------------------------------
module terminal_key_sequence_matcher_unit_tb;

    localparam int NUM_ENTRIES = 128;
    localparam int SEQ_LEN     = 8;
    localparam int IDLE_LIMIT  = 40000;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                push = 1'b0;
    logic                full;
    tksm_pkg::t_in_item  i_item = '0;
    logic                empty;
    logic                pop = 1'b0;
    tksm_pkg::t_out_item o_result;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [1:0]          i_cfg_index = '0;
    logic [15:0]         i_cfg_data = '0;

    int  error_count = 0;
    int  idle_cycles = 0;
    int  hold_off = 0;
    bit  stall_pattern_on = 1'b1;

    always #5 i_clk = ~i_clk;

    terminal_key_sequence_matcher_unit u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full), .i_item(i_item),
        .empty(empty), .pop(pop), .o_result(o_result), .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        error_count++;
    endtask

    class key_scoreboard;
        logic [7:0]  seq_mem [NUM_ENTRIES][SEQ_LEN];
        logic [15:0] code_mem [NUM_ENTRIES];
        bit          in_match;
        int          cur_entry;
        int          match_pos;
        logic [7:0]  lead_byte;
        int          tick_count;
        int          active_cnt;
        int          timeout_val;
        bit          strict_on;
        tksm_pkg::t_out_item pending_keys[$];

        function new();
            in_match = 0; cur_entry = 0; match_pos = 0; lead_byte = 0; tick_count = 0;
            active_cnt = 0; timeout_val = tksm_pkg::TIMEOUT_RESET; strict_on = 0;
            for (int e = 0; e < NUM_ENTRIES; e++) begin
                code_mem[e] = '0;
                for (int p = 0; p < SEQ_LEN; p++) seq_mem[e][p] = '0;
            end
        endfunction

        function void set_reg(tksm_pkg::t_cfg_reg idx, logic [15:0] val);
            case (idx)
                tksm_pkg::CFG_ACTIVE:  active_cnt = val[7:0];
                tksm_pkg::CFG_TIMEOUT: timeout_val = val;
                tksm_pkg::CFG_STRICT:  strict_on = val[0];
                default: ;
            endcase
        endfunction

        function logic [7:0] seq_byte(int e, int p);
            if (e >= NUM_ENTRIES || p >= SEQ_LEN) return 8'd0;
            return seq_mem[e][p];
        endfunction

        function bit prefixes_agree(int a, int b, int n);
            logic [7:0] x;
            for (int i = 0; i < n; i++) begin
                x = seq_byte(a, i);
                if (x != seq_byte(b, i)) return 0;
                if (x == 0) break;
            end
            return 1;
        endfunction

        function void add_key(logic [15:0] v, tksm_pkg::t_status s);
            tksm_pkg::t_out_item r;
            r.key_value = v;
            r.status = s;
            pending_keys.push_back(r);
        endfunction

        function void decode_byte(logic [7:0] c);
            int n, k, m, prev;
            n = (active_cnt > NUM_ENTRIES) ? NUM_ENTRIES : active_cnt;
            if (!in_match) begin
                for (k = 0; k < n; k++) if (seq_byte(k, 0) == c) break;
                if (k >= n) begin
                    add_key({8'd0, c}, tksm_pkg::ST_PLAIN);
                    return;
                end
                if (seq_byte(k, 1) == 0) begin
                    add_key(code_mem[k], tksm_pkg::ST_MATCHED);
                    return;
                end
                in_match = 1; cur_entry = k; match_pos = 1; lead_byte = c; tick_count = 0;
                return;
            end
            m = match_pos;
            if (seq_byte(cur_entry, m) != c) begin
                prev = cur_entry;
                for (k = prev + 1; k < n; k++) if (seq_byte(k, m) == c) break;
                if (k >= n || seq_byte(prev, m - 1) != seq_byte(k, m - 1) ||
                    (strict_on && m > 1 && !prefixes_agree(prev, k, m - 1))) begin
                    in_match = 0;
                    add_key(16'd0, tksm_pkg::ST_UNKNOWN);
                    return;
                end
                cur_entry = k;
            end
            m++;
            if (m >= SEQ_LEN || seq_byte(cur_entry, m) == 0) begin
                in_match = 0;
                add_key(code_mem[cur_entry], tksm_pkg::ST_MATCHED);
                return;
            end
            match_pos = m;
        endfunction

        function void note_input(tksm_pkg::t_in_item it);
            case (it.command)
                tksm_pkg::CMD_WR_BYTE:
                    seq_mem[it.entry_index][it.byte_position] = it.data_byte;
                tksm_pkg::CMD_WR_CODE: code_mem[it.entry_index] = it.key_code;
                tksm_pkg::CMD_RECV:    decode_byte(it.data_byte);
                default: begin
                    if (in_match) begin
                        if (tick_count < 16'hFFFF) tick_count++;
                        if (tick_count >= timeout_val) begin
                            in_match = 0;
                            add_key({8'd0, lead_byte}, tksm_pkg::ST_TIMEOUT);
                        end
                    end
                end
            endcase
        endfunction

        task check_result(tksm_pkg::t_out_item got);
            tksm_pkg::t_out_item exp_key;
            if (pending_keys.size() == 0) begin
                report_mismatch($sformatf("unexpected result %h", got));
                return;
            end
            exp_key = pending_keys.pop_front();
            if (got.status !== exp_key.status)
                report_mismatch($sformatf("status %0d, want %0d", got.status, exp_key.status));
            if (got.key_value !== exp_key.key_value)
                report_mismatch($sformatf("key %h, want %h", got.key_value,
                                          exp_key.key_value));
        endtask
    endclass

    key_scoreboard sb = new();

    // Receiver: stalls on its own pattern, or holds off entirely when asked.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (pop && !empty) sb.check_result(o_result);
            if (hold_off > 0) begin
                hold_off <= hold_off - 1;
                pop <= 1'b0;
            end else if (stall_pattern_on) begin
                pop <= ($urandom_range(0, 3) != 0);
            end else begin
                pop <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    int burst_left = 0;

    // Offers one item, with a random gap between bursts, and waits for its transfer.
    // Push stays high inside a burst and drops only for a gap or a drain.
    task automatic send_item(input tksm_pkg::t_in_item it);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = (hold_off == 0) ? $urandom_range(0, 6) : 0;
            if (gap > 0) begin
                push <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        push <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        sb.note_input(it);
    endtask

    task automatic send_cmd(input tksm_pkg::t_cmd c, input int e, input int p, input int d,
                            input int k);
        tksm_pkg::t_in_item it;
        it.command = c;
        it.entry_index = 7'(e);
        it.byte_position = 3'(p);
        it.data_byte = 8'(d);
        it.key_code = 16'(k);
        send_item(it);
    endtask

    task automatic drain();
        push <= 1'b0;
        while (sb.pending_keys.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
    endtask

    task automatic write_reg(input tksm_pkg::t_cfg_reg idx, input logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.set_reg(idx, val);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    logic [7:0] tbl [NUM_ENTRIES][SEQ_LEN];
    int         tbl_len [NUM_ENTRIES];
    int         tbl_size;

    // Builds a table of escape-like sequences, sorted by length then content.
    task automatic load_table(input int count, input int max_len);
        logic [7:0] tmp [SEQ_LEN];
        int tl, j, d;
        bit swap, dup;
        tbl_size = 0;
        while (tbl_size < count) begin
            tl = $urandom_range(1, max_len);
            for (int p = 0; p < SEQ_LEN; p++) tmp[p] = 8'd0;
            tmp[0] = ($urandom_range(0, 3) != 0) ? 8'h1b : 8'($urandom_range(1, 255));
            for (int p = 1; p < tl; p++)
                tmp[p] = ($urandom_range(0, 1)) ? 8'($urandom_range(8'h41, 8'h44))
                                                 : 8'($urandom_range(1, 255));
            dup = 0;
            for (int e = 0; e < tbl_size; e++) begin
                if (tbl_len[e] == tl) begin
                    d = 1;
                    for (int p = 0; p < SEQ_LEN; p++) if (tbl[e][p] != tmp[p]) d = 0;
                    if (d) dup = 1;
                end
            end
            if (!dup) begin
                for (int p = 0; p < SEQ_LEN; p++) tbl[tbl_size][p] = tmp[p];
                tbl_len[tbl_size] = tl;
                tbl_size++;
            end
        end
        for (int a = 0; a < tbl_size; a++) begin
            for (int b = 0; b < tbl_size - 1 - a; b++) begin
                swap = 0;
                if (tbl_len[b] > tbl_len[b + 1]) swap = 1;
                else if (tbl_len[b] == tbl_len[b + 1]) begin
                    for (j = 0; j < SEQ_LEN; j++) if (tbl[b][j] != tbl[b + 1][j]) break;
                    if (j < SEQ_LEN && tbl[b][j] > tbl[b + 1][j]) swap = 1;
                end
                if (swap) begin
                    for (int p = 0; p < SEQ_LEN; p++) begin
                        tmp[p] = tbl[b][p]; tbl[b][p] = tbl[b + 1][p]; tbl[b + 1][p] = tmp[p];
                    end
                    tl = tbl_len[b]; tbl_len[b] = tbl_len[b + 1]; tbl_len[b + 1] = tl;
                end
            end
        end
        // Every byte of every active entry is written so no read sees stale data.
        for (int e = 0; e < tbl_size; e++) begin
            for (int p = 0; p < SEQ_LEN; p++)
                send_cmd(tksm_pkg::CMD_WR_BYTE, e, p, tbl[e][p], 0);
            send_cmd(tksm_pkg::CMD_WR_CODE, e, 0, 0, $urandom);
        end
    endtask

    task automatic send_byte(input int d);
        send_cmd(tksm_pkg::CMD_RECV, $urandom, $urandom, d, $urandom);
    endtask

    task automatic send_tick();
        send_cmd(tksm_pkg::CMD_TICK, $urandom, $urandom, $urandom, $urandom);
    endtask

    // Mostly whole or partial table sequences, sometimes noise and ticks.
    task automatic random_phase(input int items);
        int e, cut, sent;
        sent = 0;
        while (sent < items) begin
            case ($urandom_range(0, 9)) inside
                [0:5]: begin
                    e = $urandom_range(0, tbl_size - 1);
                    cut = ($urandom_range(0, 3) == 0) ? $urandom_range(1, tbl_len[e])
                                                       : tbl_len[e];
                    for (int p = 0; p < cut; p++) begin
                        send_byte(tbl[e][p]);
                        sent++;
                    end
                    if (cut < tbl_len[e]) begin
                        if ($urandom_range(0, 1)) send_byte($urandom);
                        else repeat ($urandom_range(1, 3)) send_tick();
                        sent++;
                    end
                end
                [6:7]: begin
                    send_byte($urandom);
                    sent++;
                end
                default: begin
                    send_tick();
                    sent++;
                end
            endcase
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty table, passthrough extremes, idle tick, highest-index table writes.
        send_byte(8'h00);
        send_byte(8'hff);
        send_tick();
        send_cmd(tksm_pkg::CMD_WR_BYTE, 127, 7, 8'hff, 0);
        send_cmd(tksm_pkg::CMD_WR_CODE, 127, 0, 0, 16'hffff);
        drain();
        write_reg(tksm_pkg::CFG_ACTIVE, 16'd3);
        write_reg(tksm_pkg::CFG_TIMEOUT, 16'd1);
        write_reg(tksm_pkg::CFG_STRICT, 16'd1);
        for (int p = 0; p < SEQ_LEN; p++) begin
            send_cmd(tksm_pkg::CMD_WR_BYTE, 0, p, (p == 0) ? 8'h7f : 8'h00, 0);
            send_cmd(tksm_pkg::CMD_WR_BYTE, 1, p, (p < 3) ? 8'h1b + p : 8'h00, 0);
            send_cmd(tksm_pkg::CMD_WR_BYTE, 2, p, 8'h1b + (p == 2 ? 3 : p), 0);
        end
        send_cmd(tksm_pkg::CMD_WR_CODE, 0, 0, 0, 16'h0000);
        send_cmd(tksm_pkg::CMD_WR_CODE, 1, 0, 0, 16'h1234);
        send_cmd(tksm_pkg::CMD_WR_CODE, 2, 0, 0, 16'hffff);
        send_byte(8'h7f);                     // one-byte sequence
        send_byte(8'h1b); send_byte(8'h1c); send_byte(8'h1d);
        send_byte(8'h1b); send_byte(8'h1c); send_byte(8'h1e);   // switch entries
        for (int p = 0; p < SEQ_LEN; p++) send_byte(8'h1b + (p == 2 ? 3 : p));
        send_byte(8'h1b); send_tick();        // timeout on first tick
        send_byte(8'h1b); send_byte(8'h55);   // unknown
        drain();

        write_reg(tksm_pkg::CFG_ACTIVE, 16'd200);   // clamps to the table size
        write_reg(tksm_pkg::CFG_TIMEOUT, 16'd0);
        send_byte(8'h1b); send_tick();
        drain();

        for (int phase = 0; phase < 4; phase++) begin
            write_reg(tksm_pkg::CFG_ACTIVE, 16'd0);
            load_table((phase == 3) ? 24 : $urandom_range(2, 12), (phase == 0) ? 3 : 8);
            drain();
            write_reg(tksm_pkg::CFG_ACTIVE, 16'(tbl_size));
            write_reg(tksm_pkg::CFG_TIMEOUT,
                      (phase == 1) ? 16'hffff : 16'($urandom_range(1, 4)));
            write_reg(tksm_pkg::CFG_STRICT, 16'(phase[0]));
            if (phase == 2) begin
                hold_off = 300;
                stall_pattern_on = 0;
            end
            random_phase((phase == 3) ? 80 : 100);
            stall_pattern_on = (phase != 1);
            drain();
        end

        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
